>>> rtl/lfsrirq_pkg.sv
// Package for the LFSR interrupt source and priority model.
// Holds widths, reset seeds, register indexes, shared types and the LFSR step function.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package lfsrirq_pkg;

   localparam int SEED_W    = 16;
   localparam int PHASE_W   = 3;
   localparam int SVC_W     = 2;
   localparam int IRQ_W     = 2;
   localparam int CSR_IDX_W = 2;
   localparam int NUM_SRC   = 3;

   localparam int FRAME_TICKS_DEF   = 5;
   localparam int ON_TICKS_DEF      = 2;
   localparam int SERVICE_TICKS_DEF = 3;

   localparam logic [SEED_W-1:0] SEED_ONE_RST   = 16'hACE1;
   localparam logic [SEED_W-1:0] SEED_TWO_RST   = 16'hBEEF;
   localparam logic [SEED_W-1:0] SEED_THREE_RST = 16'hC0DE;

   localparam logic [CSR_IDX_W-1:0] CSR_SEED_ONE   = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_SEED_TWO   = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_SEED_THREE = 2'd2;

   localparam logic [IRQ_W-1:0] IRQ_NONE  = 2'd0;
   localparam logic [IRQ_W-1:0] IRQ_ONE   = 2'd1;
   localparam logic [IRQ_W-1:0] IRQ_TWO   = 2'd2;
   localparam logic [IRQ_W-1:0] IRQ_THREE = 2'd3;

   typedef struct packed {
      logic step;
      logic restart;
   } step_ctrl_type;

   function automatic logic [SEED_W-1:0] lfsr_shift(input logic [SEED_W-1:0] v);
      logic fb;
      fb = v[0] ^ v[2] ^ v[3] ^ v[5];
      return {fb, v[SEED_W-1:1]};
   endfunction

endpackage

`default_nettype wire

>>> rtl/lfsrirq_if.sv
// Channel interfaces for the LFSR interrupt model: request, response and register write.
// Depends on lfsrirq_pkg.
`timescale 1ns / 1ps
`default_nettype none

interface lfsrirq_req_if;
   logic valid;
   logic ready;
   logic restart;
   modport source (output valid, output restart, input ready);
   modport sink (input valid, input restart, output ready);
endinterface

interface lfsrirq_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [lfsrirq_pkg::IRQ_W-1:0] irq_number;
   logic [lfsrirq_pkg::IRQ_W-1:0] cpu_mode;
   logic                          line_one;
   logic                          line_two;
   logic                          line_three;
   modport source (output valid, output irq_number, output cpu_mode, output line_one,
                   output line_two, output line_three, input ready);
   modport sink (input valid, input irq_number, input cpu_mode, input line_one,
                 input line_two, input line_three, output ready);
endinterface

interface lfsrirq_csr_if;
   logic                              valid;
   logic                              ready;
   logic [lfsrirq_pkg::CSR_IDX_W-1:0] index;
   logic [lfsrirq_pkg::SEED_W-1:0]    data;
   modport source (output valid, output index, output data, input ready);
   modport sink (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

>>> rtl/lfsrirq_source.sv
// One interrupt source: LFSR, frame phase counter and on flag, producing its line.
// Depends on lfsrirq_pkg.
`timescale 1ns / 1ps
`default_nettype none

module lfsrirq_source #(
   parameter int FRAME_TICKS = lfsrirq_pkg::FRAME_TICKS_DEF,
   parameter int ON_TICKS    = lfsrirq_pkg::ON_TICKS_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  lfsrirq_pkg::step_ctrl_type        ctrl,
   input  logic [lfsrirq_pkg::SEED_W-1:0]    seed,
   input  logic [lfsrirq_pkg::SEED_W-1:0]    reset_seed,
   output logic                              line
);
   import lfsrirq_pkg::*;

   logic [SEED_W-1:0]  lfsr_ff, lfsr_in;
   logic [PHASE_W-1:0] phase_ff, phase_in;
   logic               flag_ff, flag_in;
   logic               flag_now;

   always_comb begin
      flag_now = (phase_ff == '0) ? lfsr_ff[0] : flag_ff;
      line     = !ctrl.restart && flag_now && (phase_ff < PHASE_W'(ON_TICKS));
      lfsr_in  = lfsr_ff;
      phase_in = phase_ff;
      flag_in  = flag_ff;
      if (ctrl.step) begin
         if (ctrl.restart) begin
            lfsr_in  = seed;
            phase_in = '0;
            flag_in  = 1'b0;
         end else begin
            if (phase_ff == '0) begin
               lfsr_in = lfsr_shift(lfsr_ff);
            end
            flag_in  = flag_now;
            phase_in = (phase_ff >= PHASE_W'(FRAME_TICKS - 1)) ? '0 : phase_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         lfsr_ff  <= reset_seed;
         phase_ff <= '0;
         flag_ff  <= 1'b0;
      end else begin
         lfsr_ff  <= lfsr_in;
         phase_ff <= phase_in;
         flag_ff  <= flag_in;
      end
   end

endmodule

`default_nettype wire

>>> rtl/lfsrirq_cpu.sv
// Fixed-priority encoder over the three source lines and the CPU service model.
// Depends on lfsrirq_pkg.
`timescale 1ns / 1ps
`default_nettype none

module lfsrirq_cpu #(
   parameter int SERVICE_TICKS = lfsrirq_pkg::SERVICE_TICKS_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  lfsrirq_pkg::step_ctrl_type        ctrl,
   input  logic [lfsrirq_pkg::NUM_SRC-1:0]   lines,
   output logic [lfsrirq_pkg::IRQ_W-1:0]     irq_number,
   output logic [lfsrirq_pkg::IRQ_W-1:0]     cpu_mode
);
   import lfsrirq_pkg::*;

   logic [IRQ_W-1:0] serving_ff, serving_in, serving_next;
   logic [SVC_W-1:0] left_ff, left_in, left_next;
   logic [IRQ_W-1:0] prio;

   always_comb begin
      if (lines[0]) begin
         prio = IRQ_ONE;
      end else if (lines[1]) begin
         prio = IRQ_TWO;
      end else if (lines[2]) begin
         prio = IRQ_THREE;
      end else begin
         prio = IRQ_NONE;
      end

      serving_next = serving_ff;
      left_next    = left_ff;
      if (ctrl.restart) begin
         serving_next = IRQ_NONE;
         left_next    = '0;
      end else if (left_ff != '0) begin
         left_next = left_ff - 1'b1;
         if (left_next == '0) begin
            serving_next = IRQ_NONE;
         end
      end else if (prio != IRQ_NONE) begin
         serving_next = prio;
         left_next    = SVC_W'(SERVICE_TICKS);
      end else begin
         serving_next = IRQ_NONE;
      end

      serving_in = ctrl.step ? serving_next : serving_ff;
      left_in    = ctrl.step ? left_next : left_ff;
      irq_number = ctrl.restart ? IRQ_NONE : prio;
      cpu_mode   = serving_next;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         serving_ff <= IRQ_NONE;
         left_ff    <= '0;
      end else begin
         serving_ff <= serving_in;
         left_ff    <= left_in;
      end
   end

endmodule

`default_nettype wire

>>> rtl/lfsr_interrupt_source_priority_model.sv
// Top level of the LFSR interrupt source and priority model: seed registers,
// three sources, the priority encoder and CPU model, and the response register.
// Depends on lfsrirq_pkg, lfsrirq_if, lfsrirq_source and lfsrirq_cpu.
//
// Each request is one tick of the modeled system and yields exactly one response. The
// block takes one request per clock: the tick is evaluated in a single pass from the
// source and CPU state registers into the response register, so the response is offered
// the cycle after its request is accepted, and req_ch.ready stays high while the response
// register is empty or being taken in the same cycle. Seed writes take effect at the
// next accepted restart request; a write to an index beyond the three seeds is ignored.
`timescale 1ns / 1ps
`default_nettype none

module lfsr_interrupt_source_priority_model #(
   parameter int FRAME_TICKS   = lfsrirq_pkg::FRAME_TICKS_DEF,
   parameter int ON_TICKS      = lfsrirq_pkg::ON_TICKS_DEF,
   parameter int SERVICE_TICKS = lfsrirq_pkg::SERVICE_TICKS_DEF
) (
   input  logic          clock,
   input  logic          reset,
   lfsrirq_req_if.sink   req_ch,
   lfsrirq_rsp_if.source rsp_ch,
   lfsrirq_csr_if.sink   csr_ch
);
   import lfsrirq_pkg::*;

   logic [SEED_W-1:0]  seed_one_ff, seed_one_in;
   logic [SEED_W-1:0]  seed_two_ff, seed_two_in;
   logic [SEED_W-1:0]  seed_three_ff, seed_three_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [IRQ_W-1:0]   rsp_irq_ff, rsp_irq_in;
   logic [IRQ_W-1:0]   rsp_mode_ff, rsp_mode_in;
   logic [NUM_SRC-1:0] rsp_lines_ff, rsp_lines_in;
   logic               accept;
   step_ctrl_type      ctrl;
   logic [NUM_SRC-1:0] lines;
   logic [IRQ_W-1:0]   irq_number;
   logic [IRQ_W-1:0]   cpu_mode;

   assign req_ch.ready = !rsp_valid_ff || rsp_ch.ready;
   assign accept       = req_ch.valid && req_ch.ready;
   assign ctrl.step    = accept;
   assign ctrl.restart = req_ch.restart;
   assign csr_ch.ready = 1'b1;

   always_comb begin
      seed_one_in   = seed_one_ff;
      seed_two_in   = seed_two_ff;
      seed_three_in = seed_three_ff;
      if (csr_ch.valid) begin
         case (csr_ch.index)
            CSR_SEED_ONE: begin
               seed_one_in = csr_ch.data;
            end
            CSR_SEED_TWO: begin
               seed_two_in = csr_ch.data;
            end
            CSR_SEED_THREE: begin
               seed_three_in = csr_ch.data;
            end
            default: begin
               seed_one_in = seed_one_ff;
            end
         endcase
      end
   end

   lfsrirq_source #(.FRAME_TICKS(FRAME_TICKS), .ON_TICKS(ON_TICKS)) u_src_one (
      .clock      (clock),
      .reset      (reset),
      .ctrl       (ctrl),
      .seed       (seed_one_ff),
      .reset_seed (SEED_ONE_RST),
      .line       (lines[0])
   );

   lfsrirq_source #(.FRAME_TICKS(FRAME_TICKS), .ON_TICKS(ON_TICKS)) u_src_two (
      .clock      (clock),
      .reset      (reset),
      .ctrl       (ctrl),
      .seed       (seed_two_ff),
      .reset_seed (SEED_TWO_RST),
      .line       (lines[1])
   );

   lfsrirq_source #(.FRAME_TICKS(FRAME_TICKS), .ON_TICKS(ON_TICKS)) u_src_three (
      .clock      (clock),
      .reset      (reset),
      .ctrl       (ctrl),
      .seed       (seed_three_ff),
      .reset_seed (SEED_THREE_RST),
      .line       (lines[2])
   );

   lfsrirq_cpu #(.SERVICE_TICKS(SERVICE_TICKS)) u_cpu (
      .clock      (clock),
      .reset      (reset),
      .ctrl       (ctrl),
      .lines      (lines),
      .irq_number (irq_number),
      .cpu_mode   (cpu_mode)
   );

   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_ch.ready;
      rsp_irq_in   = rsp_irq_ff;
      rsp_mode_in  = rsp_mode_ff;
      rsp_lines_in = rsp_lines_ff;
      if (accept) begin
         rsp_valid_in = 1'b1;
         rsp_irq_in   = irq_number;
         rsp_mode_in  = cpu_mode;
         rsp_lines_in = lines;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         seed_one_ff   <= SEED_ONE_RST;
         seed_two_ff   <= SEED_TWO_RST;
         seed_three_ff <= SEED_THREE_RST;
         rsp_valid_ff  <= 1'b0;
      end else begin
         seed_one_ff   <= seed_one_in;
         seed_two_ff   <= seed_two_in;
         seed_three_ff <= seed_three_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_irq_ff   <= rsp_irq_in;
      rsp_mode_ff  <= rsp_mode_in;
      rsp_lines_ff <= rsp_lines_in;
   end

   assign rsp_ch.valid      = rsp_valid_ff;
   assign rsp_ch.irq_number = rsp_irq_ff;
   assign rsp_ch.cpu_mode   = rsp_mode_ff;
   assign rsp_ch.line_one   = rsp_lines_ff[0];
   assign rsp_ch.line_two   = rsp_lines_ff[1];
   assign rsp_ch.line_three = rsp_lines_ff[2];

endmodule

`default_nettype wire
